FILE: hw/rtl/bmp_rle_span_decoder_core_assert.svh
// Assertion macros for the BMP run-length span decoder.
`ifndef BMP_RLE_SPAN_DECODER_CORE_ASSERT_SVH
`define BMP_RLE_SPAN_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BRSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BRSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/brsd_pkg.sv
// Package: word types, parser phases and helpers for the BMP RLE span decoder.
`timescale 1ns / 1ps
`default_nettype none
package brsd_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned OUT_W   = 12;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef enum logic [2:0] {
    PH_COUNT   = 3'd0,
    PH_VALUE   = 3'd1,
    PH_ESCAPE  = 3'd2,
    PH_DX      = 3'd3,
    PH_DY      = 3'd4,
    PH_LITERAL = 3'd5,
    PH_PAD     = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       start_of_image;
  } in_word_t;

  typedef struct packed {
    logic [11:0] span_col;
    logic [11:0] span_row;
    logic [7:0]  span_count;
    logic [7:0]  span_value;
    logic        dropped;
    logic        image_done;
    logic        bounds_seen;
  } out_word_t;

  // Saturating position add, sticks at all ones.
  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [7:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {{(POS_W-7){1'b0}}, b};
    return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
  endfunction

  // Clamp a 13-bit limit register to the largest image size.
  function automatic logic [POS_W-1:0] clamp_dim(input logic [POS_W-1:0] v);
    return (v > POS_W'(MAX_DIM)) ? POS_W'(MAX_DIM) : v;
  endfunction

  // Clamp a position to the 12-bit output range.
  function automatic logic [OUT_W-1:0] clamp_out(input logic [POS_W-1:0] v);
    return v[POS_W-1] ? {OUT_W{1'b1}} : v[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bmp_rle_span_decoder_core.sv
// Top level: byte-serial BMP RLE8/RLE4 span decoder with skid-buffered output.
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------
//  in       | in_valid, in_stall, in_word    | one coded byte per word
//  out      | out_valid, out_stall, out_word | one span or notice per word
//  cfg      | cfg_we, cfg_index, cfg_wdata   | mode, width, height writes
//
//  One input word per cycle while in_stall is low; the parser update for a
//  byte is short combinational logic from the state registers into the
//  output register. Each result is registered before it shows on out_word.
//  rst_n (synchronous, low) returns parser, position and config to defaults.
//  A stalled result sits in the output register; the next result goes into
//  a one-word skid register, and in_stall rises only while that is full.
`timescale 1ns / 1ps
`default_nettype none
module bmp_rle_span_decoder_core (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire brsd_pkg::in_word_t in_word,
  output logic                 out_valid,
  input  wire                  out_stall,
  output brsd_pkg::out_word_t  out_word,
  input  wire                  cfg_we,
  input  wire  [1:0]           cfg_index,
  input  wire  [12:0]          cfg_wdata
);
  import brsd_pkg::*;

  // config registers
  logic             mode_r;
  logic [POS_W-1:0] width_r;
  logic [POS_W-1:0] height_r;

  // parser state
  phase_t           phase_r,   phase_nxt;
  logic [POS_W-1:0] col_r,     col_nxt;
  logic [POS_W-1:0] row_r,     row_nxt;
  logic [7:0]       pend_r,    pend_nxt;
  logic [7:0]       left_r,    left_nxt;
  logic             pad_r,     pad_nxt;
  logic             drop_r,    drop_nxt;
  logic             bounds_r,  bounds_nxt;
  logic             fin_r,     fin_nxt;

  // output register and skid
  logic       out_valid_r;
  out_word_t  out_word_r;
  logic       skid_valid_r;
  out_word_t  skid_word_r;

  logic       in_acc;
  logic       out_take;
  logic       has_res;
  out_word_t  res;

  // state as seen after an optional start-of-image clear
  phase_t           e_phase;
  logic [POS_W-1:0] e_col, e_row;
  logic [7:0]       e_pend, e_left;
  logic             e_pad, e_drop, e_bounds, e_fin;

  logic [POS_W-1:0] dim_w, dim_h;
  logic [POS_W:0]   run_end;
  logic             row_out;
  logic [7:0]       b;
  logic [8:0]       lit_bytes;
  logic [7:0]       per, n;
  logic [7:0]       left_dec;

  // assertion terms
  logic             done_word;
  logic             done_clean;
  logic             quiet_byte;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign b     = in_word.code_byte;
  assign dim_w = clamp_dim(width_r);
  assign dim_h = clamp_dim(height_r);

  always_comb begin
    if (in_word.start_of_image) begin
      e_phase  = PH_COUNT;
      e_col    = '0;
      e_row    = '0;
      e_pend   = '0;
      e_left   = '0;
      e_pad    = 1'b0;
      e_drop   = 1'b0;
      e_bounds = 1'b0;
      e_fin    = 1'b0;
    end else begin
      e_phase  = phase_r;
      e_col    = col_r;
      e_row    = row_r;
      e_pend   = pend_r;
      e_left   = left_r;
      e_pad    = pad_r;
      e_drop   = drop_r;
      e_bounds = bounds_r;
      e_fin    = fin_r;
    end
  end

  // Bounds test: the run count is the pending count, or the byte itself
  // when the byte opens a literal run.
  always_comb begin
    if (e_phase == PH_ESCAPE) begin
      run_end = {1'b0, e_col} + {{(POS_W-7){1'b0}}, b};
    end else begin
      run_end = {1'b0, e_col} + {{(POS_W-7){1'b0}}, e_pend};
    end
  end
  assign row_out = (e_row >= dim_h);

  assign lit_bytes = mode_r ? ((9'(b) + 9'd1) >> 1) : 9'(b);
  assign per       = mode_r ? 8'd2 : 8'd1;
  assign n         = (e_pend < per) ? e_pend : per;
  assign left_dec  = (e_left != 8'd0) ? (e_left - 8'd1) : e_left;

  always_comb begin
    phase_nxt  = e_phase;
    col_nxt    = e_col;
    row_nxt    = e_row;
    pend_nxt   = e_pend;
    left_nxt   = e_left;
    pad_nxt    = e_pad;
    drop_nxt   = e_drop;
    bounds_nxt = e_bounds;
    fin_nxt    = e_fin;
    has_res    = 1'b0;
    res.span_col   = clamp_out(e_col);
    res.span_row   = clamp_out(e_row);
    res.span_count = 8'd0;
    res.span_value = 8'd0;
    res.dropped    = 1'b0;
    res.image_done = 1'b0;
    if (!e_fin) begin
      case (e_phase)
        PH_VALUE: begin
          phase_nxt = PH_COUNT;
          has_res   = 1'b1;
          if ((run_end > {1'b0, dim_w}) || row_out) begin
            bounds_nxt  = 1'b1;
            res.dropped = 1'b1;
          end else begin
            res.span_count = e_pend;
            res.span_value = b;
            col_nxt        = sat_add(e_col, e_pend);
          end
        end
        PH_ESCAPE: begin
          if (b == ESC_EOL) begin
            col_nxt   = '0;
            row_nxt   = sat_add(e_row, 8'd1);
            phase_nxt = PH_COUNT;
          end else if (b == ESC_EOB) begin
            fin_nxt        = 1'b1;
            phase_nxt      = PH_COUNT;
            has_res        = 1'b1;
            res.image_done = 1'b1;
          end else if (b == ESC_DELTA) begin
            phase_nxt = PH_DX;
          end else begin
            pend_nxt  = b;
            left_nxt  = lit_bytes[7:0];
            pad_nxt   = lit_bytes[0];
            phase_nxt = PH_LITERAL;
            if ((run_end > {1'b0, dim_w}) || row_out) begin
              drop_nxt    = 1'b1;
              bounds_nxt  = 1'b1;
              has_res     = 1'b1;
              res.dropped = 1'b1;
            end else begin
              drop_nxt = 1'b0;
            end
          end
        end
        PH_DX: begin
          pend_nxt  = b;
          phase_nxt = PH_DY;
        end
        PH_DY: begin
          col_nxt   = sat_add(e_col, e_pend);
          row_nxt   = sat_add(e_row, b);
          pend_nxt  = '0;
          phase_nxt = PH_COUNT;
        end
        PH_LITERAL: begin
          if (!e_drop) begin
            has_res        = 1'b1;
            res.span_count = n;
            res.span_value = b;
            col_nxt        = sat_add(e_col, n);
            pend_nxt       = e_pend - n;
          end
          left_nxt = left_dec;
          if (left_dec == 8'd0) begin
            phase_nxt = e_pad ? PH_PAD : PH_COUNT;
            pad_nxt   = 1'b0;
            drop_nxt  = 1'b0;
            pend_nxt  = '0;
          end
        end
        PH_PAD: begin
          phase_nxt = PH_COUNT;
        end
        default: begin
          // count byte; zero opens an escape
          if (b != 8'd0) begin
            pend_nxt  = b;
            phase_nxt = PH_VALUE;
          end else begin
            phase_nxt = PH_ESCAPE;
          end
        end
      endcase
    end
    res.bounds_seen = bounds_nxt;
  end

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= POS_W'(MAX_DIM);
      height_r <= POS_W'(MAX_DIM);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode_r   <= cfg_wdata[0];
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_COUNT;
      col_r    <= '0;
      row_r    <= '0;
      pend_r   <= '0;
      left_r   <= '0;
      pad_r    <= 1'b0;
      drop_r   <= 1'b0;
      bounds_r <= 1'b0;
      fin_r    <= 1'b0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pend_r   <= pend_nxt;
      left_r   <= left_nxt;
      pad_r    <= pad_nxt;
      drop_r   <= drop_nxt;
      bounds_r <= bounds_nxt;
      fin_r    <= fin_nxt;
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc && has_res) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_word_r <= skid_word_r;
      end
    end else if (in_acc && has_res) begin
      if (out_valid_r && !out_take) begin
        skid_word_r <= res;
      end else begin
        out_word_r <= res;
      end
    end
  end

  assign done_word  = out_valid_r && out_word_r.image_done;
  assign done_clean = (out_word_r.span_count == 8'd0) && !out_word_r.dropped;
  assign quiet_byte = in_acc && fin_r && !in_word.start_of_image && !out_valid_r;

`include "bmp_rle_span_decoder_core_assert.svh"

  `BRSD_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with output empty")
  `BRSD_ASSERT_NEXT(a_held_result, out_valid_r && out_stall, out_valid_r, "stalled result lost")
  `BRSD_ASSERT_NOW(a_done_notice, done_word, done_clean, "end notice carries pixels")
  `BRSD_ASSERT_NEXT(a_quiet_when_done, quiet_byte, !out_valid_r, "result after end of bitmap")

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for bmp_rle_span_decoder_core: directed and random RLE streams checked word by word.
`timescale 1ns / 1ps
module tb;
  import brsd_pkg::*;

  // ------------------------------------------------------------------
  // Clock, reset and DUT ports
  // ------------------------------------------------------------------
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bmp_rle_span_decoder_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ------------------------------------------------------------------
  // Shared control
  // ------------------------------------------------------------------
  bit idle_on = 1'b1;     // random gaps on the sender and stalls on the receiver
  bit mark_sof = 1'b0;    // next word carries start_of_image
  int hold_cycles = 0;    // long receiver hold-off, counted down by the stall process
  int burst_left = 0;
  int fed_bytes = 0;
  int mismatches = 0;

  // ------------------------------------------------------------------
  // Span predictor: own copy of config and parser state
  // ------------------------------------------------------------------
  logic        img_4bit = 1'b0;
  logic [12:0] img_w = 13'd4096;
  logic [12:0] img_h = 13'd4096;

  phase_t      dec_phase = PH_COUNT;
  logic [12:0] dec_col = '0;
  logic [12:0] dec_row = '0;
  logic [7:0]  dec_pend = '0;   // run count, or dx during a delta
  logic [7:0]  dec_left = '0;   // literal data bytes still to come
  logic        dec_pad = 1'b0;
  logic        dec_skip = 1'b0; // literal run being thrown away
  logic        dec_oob = 1'b0;  // sticky bounds flag
  logic        dec_done = 1'b0; // end of bitmap seen

  out_word_t span_q[$];         // spans and notices still to come out

  // Position add that sticks at 8191
  function automatic logic [12:0] pos_add(input logic [12:0] a, input logic [7:0] b);
    int s;
    s = int'(a) + int'(b);
    return (s > 8191) ? 13'h1FFF : s[12:0];
  endfunction

  function automatic int dim_limit(input logic [12:0] v);
    return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic logic run_leaves(input int cnt);
    return (int'(dec_col) + cnt > dim_limit(img_w)) || (int'(dec_row) >= dim_limit(img_h));
  endfunction

  // Coordinates clamp to 4095 on the way out
  function automatic out_word_t span_word(input int cnt, input logic [7:0] val,
                                          input logic drop, input logic done);
    out_word_t r;
    r.span_col    = (dec_col > 13'd4095) ? 12'hFFF : dec_col[11:0];
    r.span_row    = (dec_row > 13'd4095) ? 12'hFFF : dec_row[11:0];
    r.span_count  = 8'(cnt);
    r.span_value  = val;
    r.dropped     = drop;
    r.image_done  = done;
    r.bounds_seen = dec_oob;
    return r;
  endfunction

  // Advance the predictor by one accepted word
  task automatic decode_byte(input in_word_t w);
    logic [7:0] b;
    int n;
    b = w.code_byte;
    if (w.start_of_image) begin
      dec_phase = PH_COUNT;
      dec_col = '0;
      dec_row = '0;
      dec_pend = '0;
      dec_left = '0;
      dec_pad = 1'b0;
      dec_skip = 1'b0;
      dec_oob = 1'b0;
      dec_done = 1'b0;
    end
    if (dec_done) return;
    case (dec_phase)
      PH_VALUE: begin
        dec_phase = PH_COUNT;
        if (run_leaves(int'(dec_pend))) begin
          dec_oob = 1'b1;
          span_q.push_back(span_word(0, 8'h00, 1'b1, 1'b0));
        end else begin
          span_q.push_back(span_word(int'(dec_pend), b, 1'b0, 1'b0));
          dec_col = pos_add(dec_col, dec_pend);
        end
      end
      PH_ESCAPE: begin
        if (b == ESC_EOL) begin
          dec_col = '0;
          dec_row = pos_add(dec_row, 8'd1);
          dec_phase = PH_COUNT;
        end else if (b == ESC_EOB) begin
          dec_done = 1'b1;
          dec_phase = PH_COUNT;
          span_q.push_back(span_word(0, 8'h00, 1'b0, 1'b1));
        end else if (b == ESC_DELTA) begin
          dec_phase = PH_DX;
        end else begin
          // absolute run: 4-bit packs two pixels per byte
          dec_pend = b;
          dec_left = img_4bit ? 8'((int'(b) + 1) >> 1) : b;
          dec_pad = dec_left[0];
          dec_phase = PH_LITERAL;
          if (run_leaves(int'(b))) begin
            dec_skip = 1'b1;
            dec_oob = 1'b1;
            span_q.push_back(span_word(0, 8'h00, 1'b1, 1'b0));
          end else begin
            dec_skip = 1'b0;
          end
        end
      end
      PH_DX: begin
        dec_pend = b;
        dec_phase = PH_DY;
      end
      PH_DY: begin
        dec_col = pos_add(dec_col, dec_pend);
        dec_row = pos_add(dec_row, b);
        dec_pend = '0;
        dec_phase = PH_COUNT;
      end
      PH_LITERAL: begin
        if (!dec_skip) begin
          n = img_4bit ? 2 : 1;
          if (int'(dec_pend) < n) n = int'(dec_pend);
          span_q.push_back(span_word(n, b, 1'b0, 1'b0));
          dec_col = pos_add(dec_col, 8'(n));
          dec_pend = dec_pend - 8'(n);
        end
        if (dec_left > 0) dec_left = dec_left - 8'd1;
        if (dec_left == 0) begin
          dec_phase = dec_pad ? PH_PAD : PH_COUNT;
          dec_pad = 1'b0;
          dec_skip = 1'b0;
          dec_pend = '0;
        end
      end
      PH_PAD: begin
        dec_phase = PH_COUNT;
      end
      default: begin
        if (b != 8'h00) begin
          dec_pend = b;
          dec_phase = PH_VALUE;
        end else begin
          dec_phase = PH_ESCAPE;
        end
      end
    endcase
  endtask

  // ------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------
  task automatic report_mismatch(input string why, input out_word_t e, input out_word_t a);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: exp col=%0d row=%0d cnt=%0d val=%02h drop=%b done=%b oob=%b",
               $realtime, why, e.span_col, e.span_row, e.span_count, e.span_value,
               e.dropped, e.image_done, e.bounds_seen);
      $display("    got col=%0d row=%0d cnt=%0d val=%02h drop=%b done=%b oob=%b",
               a.span_col, a.span_row, a.span_count, a.span_value,
               a.dropped, a.image_done, a.bounds_seen);
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (span_q.size() == 0) begin
        report_mismatch("unexpected word", '0, out_word);
      end else begin
        e = span_q.pop_front();
        if (out_word.span_col !== e.span_col || out_word.span_row !== e.span_row ||
            out_word.span_count !== e.span_count || out_word.span_value !== e.span_value ||
            out_word.dropped !== e.dropped || out_word.image_done !== e.image_done ||
            out_word.bounds_seen !== e.bounds_seen)
          report_mismatch("span mismatch", e, out_word);
      end
    end
  end

  // Receiver: long hold-off when asked, otherwise random stall bursts
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      burst_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  // Offer one word; returns at the edge that accepts it
  task automatic send_byte(input logic [7:0] b, input logic sof = 1'b0);
    in_word_t w;
    w.code_byte = b;
    w.start_of_image = sof | mark_sof;
    mark_sof = 1'b0;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fed_bytes++;
    decode_byte(w);
  endtask

  task automatic send_encoded(input int cnt, input logic [7:0] val);
    send_byte(8'(cnt));
    send_byte(val);
  endtask

  task automatic send_eol();
    send_byte(8'h00);
    send_byte(ESC_EOL);
  endtask

  task automatic send_eob();
    send_byte(8'h00);
    send_byte(ESC_EOB);
  endtask

  task automatic send_delta(input int dx, input int dy);
    send_byte(8'h00);
    send_byte(ESC_DELTA);
    send_byte(8'(dx));
    send_byte(8'(dy));
  endtask

  // Absolute run of cnt pixels (3..255), random data, word padding
  task automatic send_literal(input int cnt);
    int nbytes;
    nbytes = img_4bit ? (cnt + 1) / 2 : cnt;
    send_byte(8'h00);
    send_byte(8'(cnt));
    repeat (nbytes) send_byte(8'($urandom));
    if (nbytes % 2) send_byte(8'($urandom));
  endtask

  // Drain everything, then give the pipeline time to finish no-result words
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (span_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers while idle
  task automatic set_image(input logic m, input logic [12:0] w, input logic [12:0] h);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_wdata <= 13'(m);
    @(posedge clk);
    cfg_index <= REG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    img_4bit = m;
    img_w = w;
    img_h = h;
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // 8-bit: kept run, dropped run, run ending on the right edge, line end,
  // delta, padded literal, literal off the bottom, end of bitmap, ignored tail
  task automatic test_rle8_basics();
    set_image(1'b0, 13'd16, 13'd3);
    mark_sof = 1'b1;
    send_encoded(3, 8'hAB);
    send_encoded(255, 8'h00);
    send_encoded(13, 8'hFF);
    send_eol();
    send_delta(2, 1);
    send_literal(3);
    send_delta(0, 1);
    send_literal(3);
    send_eob();
    send_byte(8'h5A);
    send_byte(8'h00);
  endtask

  // 4-bit: nibble-packed literals with and without pad, row limit, restart after end
  task automatic test_rle4_basics();
    set_image(1'b1, 13'd8, 13'd2);
    mark_sof = 1'b1;
    send_encoded(5, 8'h3C);
    send_encoded(4, 8'hC3);
    send_literal(3);
    send_eol();
    send_literal(5);
    send_eol();
    send_encoded(1, 8'h77);
    send_eob();
    mark_sof = 1'b1;
    send_encoded(2, 8'h12);
    send_eob();
  endtask

  // Zero limits drop everything; oversize limits act as 4096; positions saturate
  task automatic test_limits();
    set_image(1'b0, 13'd0, 13'd0);
    mark_sof = 1'b1;
    send_encoded(1, 8'h01);
    send_eob();
    set_image(1'b1, 13'h1FFF, 13'h1FFF);
    mark_sof = 1'b1;
    send_encoded(255, 8'hE7);
    repeat (33) send_delta(255, 255);
    send_encoded(1, 8'h11);
    send_eob();
  endtask

  // Receiver holds off while a long literal streams in, so the input stalls
  task automatic test_backpressure();
    set_image(1'b0, 13'd4096, 13'd4096);
    idle_on = 1'b0;
    hold_cycles = 60;
    mark_sof = 1'b1;
    send_literal(40);
    wait_idle();
    idle_on = 1'b1;
  endtask

  // Mostly well-formed images with random content, some raw noise
  task automatic random_image(input int ops);
    int pick;
    mark_sof = 1'b1;
    repeat (ops) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_encoded(($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6),
                     8'($urandom));
      else if (pick < 58)
        send_literal(($urandom_range(0, 19) == 0) ? $urandom_range(3, 255)
                                                  : $urandom_range(3, 12));
      else if (pick < 78)
        send_eol();
      else if (pick < 93)
        send_delta(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 3),
                   ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 2));
      else
        send_byte(8'($urandom));   // stray byte knocks the parser out of step
    end
    if ($urandom_range(0, 7) != 0) begin
      send_eob();
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
    end
  endtask

  task automatic test_random_streams(input logic m, input logic [12:0] w, input logic [12:0] h,
                                     input int nbytes, input bit idles);
    int stop_at;
    set_image(m, w, h);
    idle_on = idles;
    stop_at = fed_bytes + nbytes;
    while (fed_bytes < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        random_image($urandom_range(3, 15));
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_rle8_basics();
    test_rle4_basics();
    test_limits();
    test_backpressure();
    test_random_streams(1'b0, 13'd16, 13'd6, 80, 1'b1);
    test_random_streams(1'b1, 13'd9, 13'd4, 80, 1'b1);
    test_random_streams(1'b0, 13'd4096, 13'd4096, 80, 1'b1);
    test_random_streams(1'b1, 13'd1, 13'd1, 80, 1'b1);
    test_random_streams(1'b0, 13'd300, 13'd40, 80, 1'b1);
    // closing phase runs flat out on both sides
    test_random_streams(1'b1, 13'd40, 13'd12, 80, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: a lost span never drains the queue
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/brsd_pkg.sv
hw/rtl/bmp_rle_span_decoder_core.sv
dv/tb.sv
